>>> rtl/fmc_pkg.sv
`default_nettype none

package fmc_pkg;

  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [6:0]  ManualSpeedRst = 7'd50;
  localparam logic [15:0] LockoutMsRst   = 16'd500;
  localparam logic [15:0] BurstHalfMsRst = 16'd300;
  localparam logic [6:0]  FullSpeed      = 7'd100;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexWidth-1:0] RegManualSpeed = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegLockoutMs   = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegBurstHalfMs = 2'd2;

  // Mode codes as reported on the result channel.
  localparam logic [1:0] ModeManual = 2'd0;
  localparam logic [1:0] ModeAuto   = 2'd1;
  localparam logic [1:0] ModeBurst  = 2'd2;
  localparam logic [1:0] ModeStop   = 2'd3;

  typedef enum logic [3:0] {
    StManual = 4'b0001,
    StAuto   = 4'b0010,
    StBurst  = 4'b0100,
    StStop   = 4'b1000
  } fmc_state_e;

  typedef struct packed {
    logic [6:0]  manual_speed;
    logic [15:0] lockout_ms;
    logic [15:0] burst_half_ms;
  } fmc_cfg_t;

  typedef struct packed {
    logic [6:0] speed_percent;
    logic [1:0] mode;
    logic       mode_changed;
    logic       motor_stopped;
  } fmc_result_t;

  function automatic logic [1:0] mode_code(fmc_state_e st);
    logic [1:0] code;
    unique case (st)
      StManual: code = ModeManual;
      StAuto:   code = ModeAuto;
      StBurst:  code = ModeBurst;
      StStop:   code = ModeStop;
      default:  code = ModeManual;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fmc_in_if.sv
`default_nettype none

interface fmc_in_if;
  logic               valid;
  logic               ready;
  logic               button_level;
  logic signed [11:0] temperature_tenths;

  modport source (output valid, output button_level, output temperature_tenths,
                  input ready);
  modport sink (input valid, input button_level, input temperature_tenths,
                output ready);
endinterface

`default_nettype wire

>>> rtl/fmc_out_if.sv
`default_nettype none

interface fmc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] speed_percent;
  logic [1:0] mode;
  logic       mode_changed;
  logic       motor_stopped;

  modport source (output valid, output speed_percent, output mode,
                  output mode_changed, output motor_stopped, input ready);
  modport sink (input valid, input speed_percent, input mode,
                input mode_changed, input motor_stopped, output ready);
endinterface

`default_nettype wire

>>> rtl/fmc_core.sv
`default_nettype none

module fmc_core
  import fmc_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [CfgWidth-1:0]      cfg_data_i,
  input  wire logic                     accept_i,
  input  wire logic                     button_level_i,
  input  wire logic signed [11:0]       temperature_tenths_i,
  output fmc_result_t                   result_o
);

  fmc_cfg_t   cfg_q;
  fmc_state_e state_q, state_d, state_adv;
  logic       prev_level_q;
  logic [15:0] since_q, since_d, since_inc;
  logic [15:0] burst_timer_q, burst_timer_d, timer_base, timer_inc;
  logic        burst_on_q, burst_on_d, on_base;
  logic        press;
  logic [10:0] temp_mag;
  logic [23:0] temp_prod;
  logic [8:0]  temp_div5;
  logic [6:0]  auto_speed;
  logic [6:0]  manual_speed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.manual_speed  <= ManualSpeedRst;
      cfg_q.lockout_ms    <= LockoutMsRst;
      cfg_q.burst_half_ms <= BurstHalfMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegManualSpeed: cfg_q.manual_speed  <= cfg_data_i[6:0];
        RegLockoutMs:   cfg_q.lockout_ms    <= cfg_data_i;
        RegBurstHalfMs: cfg_q.burst_half_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (state_q)
      StManual: state_adv = StAuto;
      StAuto:   state_adv = StBurst;
      StBurst:  state_adv = StStop;
      StStop:   state_adv = StManual;
      default:  state_adv = StManual;
    endcase
  end

  // Division by five through a reciprocal; exact for magnitudes below 2048.
  assign temp_mag  = temperature_tenths_i[10:0];
  assign temp_prod = {13'd0, temp_mag} * 24'd6554;
  assign temp_div5 = temp_prod[23:15];

  always_comb begin
    if (temperature_tenths_i[11] || temp_mag == 11'd0) begin
      auto_speed = 7'd0;
    end else if (temp_div5 > {2'd0, FullSpeed}) begin
      auto_speed = FullSpeed;
    end else begin
      auto_speed = temp_div5[6:0];
    end
  end

  assign manual_speed = (cfg_q.manual_speed > FullSpeed) ? FullSpeed : cfg_q.manual_speed;

  assign since_inc = (since_q == 16'hFFFF) ? since_q : since_q + 16'd1;
  assign press     = prev_level_q && !button_level_i && (since_inc > cfg_q.lockout_ms);
  assign state_d   = press ? state_adv : state_q;
  assign since_d   = press ? 16'd0 : since_inc;

  always_comb begin
    if (press && state_adv == StBurst) begin
      timer_base = 16'd0;
      on_base    = 1'b1;
    end else begin
      timer_base = burst_timer_q;
      on_base    = burst_on_q;
    end
    timer_inc     = timer_base + 16'd1;
    burst_timer_d = timer_base;
    burst_on_d    = on_base;
    result_o.mode          = mode_code(state_d);
    result_o.mode_changed  = press;
    result_o.motor_stopped = 1'b0;
    unique case (state_d)
      StManual: result_o.speed_percent = manual_speed;
      StAuto:   result_o.speed_percent = auto_speed;
      StBurst: begin
        result_o.speed_percent = on_base ? FullSpeed : 7'd0;
        // A zero half period acts as one, since the compare always holds.
        if (timer_inc >= cfg_q.burst_half_ms) begin
          burst_timer_d = 16'd0;
          burst_on_d    = !on_base;
        end else begin
          burst_timer_d = timer_inc;
        end
      end
      StStop: begin
        result_o.speed_percent = 7'd0;
        result_o.motor_stopped = 1'b1;
      end
      default: result_o.speed_percent = 7'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StManual;
      prev_level_q  <= 1'b1;
      since_q       <= 16'd0;
      burst_timer_q <= 16'd0;
      burst_on_q    <= 1'b1;
    end else if (accept_i) begin
      state_q       <= state_d;
      prev_level_q  <= button_level_i;
      since_q       <= since_d;
      burst_timer_q <= burst_timer_d;
      burst_on_q    <= burst_on_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fmc_skid.sv
`default_nettype none

module fmc_skid
  import fmc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire fmc_result_t data_i,
  output logic             ready_o,
  fmc_out_if.source        out_res
);

  fmc_result_t main_q, skid_q;
  logic        main_valid_q, skid_valid_q;
  logic        pop;

  assign pop     = main_valid_q && out_res.ready;
  assign ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || pop) begin
      main_valid_q <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || pop) begin
      main_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign out_res.valid         = main_valid_q;
  assign out_res.speed_percent = main_q.speed_percent;
  assign out_res.mode          = main_q.mode;
  assign out_res.mode_changed  = main_q.mode_changed;
  assign out_res.motor_stopped = main_q.motor_stopped;

endmodule

`default_nettype wire

>>> rtl/fan_mode_controller_unit.sv
`default_nettype none

// Fan mode controller. Each request is one millisecond tick with the button
// level and the temperature; each yields exactly one result with the speed,
// the mode, a press flag and the motor-stop flag. One request is taken every
// clock cycle unless the input stalls, and its result is registered in the
// output buffer: the mode, lockout and burst counters are updated at
// acceptance. A two-entry output buffer keeps requests flowing while a result
// waits, so the input only stalls once two results are held. Configuration
// writes take effect on the next cycle and belong in idle periods.
module fan_mode_controller_unit
  import fmc_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  fmc_in_if.sink                        in_req,
  fmc_out_if.source                     out_res,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [CfgWidth-1:0]      cfg_data_i
);

  fmc_result_t result;
  logic        accept;
  logic        buf_ready;

  assign in_req.ready = buf_ready;
  assign accept       = in_req.valid && buf_ready;

  fmc_core u_core (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .accept_i             (accept),
    .button_level_i       (in_req.button_level),
    .temperature_tenths_i (in_req.temperature_tenths),
    .result_o             (result)
  );

  fmc_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .ready_o (buf_ready),
    .out_res (out_res)
  );

`ifndef SYNTH
  a_stop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_res.valid |-> (out_res.motor_stopped == (out_res.mode == ModeStop)))
    else $error("motor stop flag disagrees with mode");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_res.valid |-> (out_res.speed_percent <= FullSpeed &&
                       (!out_res.motor_stopped || out_res.speed_percent == 7'd0)))
    else $error("speed out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_req.ready |-> out_res.valid)
    else $error("input stalled with no result pending");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req.valid && in_req.ready) |=> out_res.valid)
    else $error("accepted request produced no result");
`endif

endmodule

`default_nettype wire
